[design/go_to_point_steering_assert.svh]
// Assertion helpers shared by the steering block.
`ifndef GO_TO_POINT_STEERING_ASSERT_SVH
`define GO_TO_POINT_STEERING_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define GTP_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");

// Same-cycle implication.
`define GTP_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

`endif

[design/gtp_pkg.sv]
package gtp_pkg;

	localparam int DW = 33;
	localparam int CW = 38;
	localparam int ZW = 34;
	localparam int EW = 36;
	localparam int SQW = 64;

	localparam logic signed [ZW-1:0] ANG_PI = 34'sd3373259426;
	localparam logic signed [EW-1:0] ANG_TWO_PI = 36'sd6746518852;

	typedef enum logic [1:0] {
		REG_TARGET_X = 2'd0,
		REG_TARGET_Y = 2'd1,
		REG_STOP_RADIUS = 2'd2,
		REG_MAX_SPEED = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic [30:0] stop_radius;
		logic [30:0] max_speed;
	} cfg_t;

	typedef struct packed {
		logic far;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [CW-1:0] yaw_x;
		logic signed [CW-1:0] yaw_y;
	} qitem_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = (i < 31) ? (ZW'(1) <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

[design/gtp_front.sv]
module gtp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  gtp_pkg::cfg_t cfg,
	output logic out_valid,
	output gtp_pkg::qitem_t out_item
);
	import gtp_pkg::*;

	logic valid_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, wz_s1, xy_s1;
	logic valid_s2;
	qitem_t item_s2;

	logic signed [32:0] cross_sum;
	logic signed [33:0] yaw_y_w, yaw_x_w;
	logic far_w;

	always_comb begin
		cross_sum = 33'(wz_s1) + 33'(xy_s1);
		yaw_y_w = {cross_sum, 1'b0};
		yaw_x_w = 34'(ww_s1) + 34'(xx_s1) - 34'(yy_s1) - 34'(zz_s1);
		far_w = (dx_s1[32] != dx_s1[31]) || (dx_s1 == {2'b11, 31'd0})
			|| (dy_s1[32] != dy_s1[31]) || (dy_s1 == {2'b11, 31'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(cfg.target_x) - 33'(pos_x);
		dy_s1 <= 33'(cfg.target_y) - 33'(pos_y);
		ww_s1 <= quat_w * quat_w;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
		item_s2.far <= far_w;
		item_s2.dx <= dx_s1;
		item_s2.dy <= dy_s1;
		item_s2.yaw_x <= CW'(yaw_x_w);
		item_s2.yaw_y <= CW'(yaw_y_w);
	end

	assign out_valid = valid_s2;
	assign out_item = item_s2;

endmodule

[design/gtp_fifo.sv]
module gtp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] din,
	input  logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	assign dout = mem_q[rd_q];
	assign empty = (cnt_q == '0);

endmodule

[design/gtp_back.sv]
module gtp_back #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  gtp_pkg::qitem_t in_item,
	output logic in_pop,
	input  gtp_pkg::cfg_t cfg,
	output logic out_valid,
	input  logic out_ready,
	output logic [30:0] linear_speed,
	output logic signed [15:0] angular_rate,
	output logic arrived
);
	import gtp_pkg::*;

	localparam int NIT = 32;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cv_t;

	typedef struct packed {
		logic far;
		logic [SQW-1:0] rem;
		logic [SQW-1:0] res;
		cv_t bv;
		cv_t yv;
		logic bzero;
		logic yzero;
	} it_t;

	function automatic cv_t crd_pre(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		cv_t r;
		r.x = x;
		r.y = y;
		r.z = '0;
		if (x < 0) begin
			r.z = (y >= 0) ? ANG_PI : -ANG_PI;
			r.x = -x;
			r.y = -y;
		end
		return r;
	endfunction

	function automatic cv_t crd_step(input cv_t a, input int unsigned i);
		cv_t r;
		logic signed [CW-1:0] xs, ys;
		xs = a.x >>> i;
		ys = a.y >>> i;
		if (a.y > 0) begin
			r.x = a.x + ys;
			r.y = a.y - xs;
			r.z = a.z + atan_q30(i);
		end else begin
			r.x = a.x - ys;
			r.y = a.y + xs;
			r.z = a.z - atan_q30(i);
		end
		return r;
	endfunction

	logic en;
	logic vld_q [NIT+2];
	it_t st_q [NIT+2];
	it_t nx [NIT];
	it_t p0;
	it_t p1;
	logic [DW-1:0] adx, ady;

	logic f_vld_q, f_arr_q;
	logic [30:0] f_speed_q;
	logic signed [EW-1:0] f_err_q;
	logic o_vld_q;

	logic [31:0] distance;
	logic signed [ZW-1:0] bz, yz;
	logic signed [EW-1:0] err0, err1, err2, rnd;

	assign en = !o_vld_q || out_ready;
	assign in_pop = en && in_valid;

	always_comb begin
		adx = in_item.dx[DW-1] ? -in_item.dx : in_item.dx;
		ady = in_item.dy[DW-1] ? -in_item.dy : in_item.dy;
		p0.far = in_item.far;
		p0.rem = SQW'(adx[30:0] * adx[30:0]);
		p0.res = SQW'(ady[30:0] * ady[30:0]);
		p0.bv = crd_pre(CW'(in_item.dx), CW'(in_item.dy));
		p0.yv = crd_pre(in_item.yaw_x, in_item.yaw_y);
		p0.bzero = (in_item.dx == '0) && (in_item.dy == '0);
		p0.yzero = (in_item.yaw_x == '0) && (in_item.yaw_y == '0);
	end

	always_comb begin
		p1 = st_q[0];
		p1.rem = st_q[0].rem + st_q[0].res;
		p1.res = '0;
	end

	always_comb begin
		logic [SQW-1:0] bitv, trial;
		for (int j = 0; j < NIT; j++) begin
			nx[j] = st_q[j+1];
			if (j < CORDIC_STAGES) begin
				nx[j].bv = crd_step(st_q[j+1].bv, j);
				nx[j].yv = crd_step(st_q[j+1].yv, j);
			end
			bitv = SQW'(1) << (62 - 2 * j);
			trial = st_q[j+1].res + bitv;
			if (st_q[j+1].rem >= trial) begin
				nx[j].rem = st_q[j+1].rem - trial;
				nx[j].res = (st_q[j+1].res >> 1) + bitv;
			end else begin
				nx[j].res = st_q[j+1].res >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NIT + 2; k++)
				vld_q[k] <= 1'b0;
			f_vld_q <= 1'b0;
			o_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_pop;
			for (int k = 1; k < NIT + 2; k++)
				vld_q[k] <= vld_q[k-1];
			f_vld_q <= vld_q[NIT+1];
			o_vld_q <= f_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= p0;
			st_q[1] <= p1;
			for (int k = 0; k < NIT; k++)
				st_q[k+2] <= nx[k];
		end
	end

	always_comb begin
		distance = st_q[NIT+1].far ? 32'h8000_0000 : st_q[NIT+1].res[31:0];
		bz = st_q[NIT+1].bzero ? '0 : st_q[NIT+1].bv.z;
		yz = st_q[NIT+1].yzero ? '0 : st_q[NIT+1].yv.z;
		err0 = EW'(bz) - EW'(yz);
		err1 = (err0 > EW'(ANG_PI)) ? err0 - ANG_TWO_PI : err0;
		err2 = (err1 <= -EW'(ANG_PI)) ? err1 + ANG_TWO_PI : err1;
		rnd = (f_err_q + EW'(65536)) >>> 17;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_arr_q <= distance < {1'b0, cfg.stop_radius};
			f_speed_q <= (distance > {1'b0, cfg.max_speed}) ? cfg.max_speed : distance[30:0];
			f_err_q <= err2;
			arrived <= f_arr_q;
			linear_speed <= f_arr_q ? '0 : f_speed_q;
			angular_rate <= f_arr_q ? '0 : rnd[15:0];
		end
	end

	assign out_valid = o_vld_q;

endmodule

[design/go_to_point_steering.sv]
// An accepted pose passes through the front stages, the queue and the back pipeline, in that order, to m_tvalid.
// Throughput: one pose per cycle while m_tready is high; the back pipeline holds on an output stall.
// The back pipeline is 36 stages long: two setup stages, 32 square root stages (one result bit
// per stage) and two output stages.
// Reset clears all valid flags and the credit counter and loads the default target,
// stop radius and speed cap; no clearing pass is needed.
module go_to_point_steering #(
	parameter int CORDIC_STAGES = 16,
	parameter int QDEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80], quat_z[111:96], quat_w[127:112]
	input  logic [127:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// linear_speed[30:0], angular_rate[46:31], zero pad[47]
	output logic [47:0] m_tdata,
	// arrived[0]
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_wdata
);
	import gtp_pkg::*;

	localparam int CRW = $clog2(QDEPTH + 1);

	cfg_t cfg_q;
	logic [CRW-1:0] credit_q;
	logic acc, fr_valid, q_empty, q_pop;
	qitem_t fr_item, q_item;
	logic [30:0] speed;
	logic signed [15:0] rate;
	logic arr;

	assign s_tready = credit_q < CRW'(QDEPTH);
	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x <= 32'sd262144;
			cfg_q.target_y <= 32'sd98304;
			cfg_q.stop_radius <= 31'd6554;
			cfg_q.max_speed <= 31'd58982;
			credit_q <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET_X: cfg_q.target_x <= cfg_wdata;
					REG_TARGET_Y: cfg_q.target_y <= cfg_wdata;
					REG_STOP_RADIUS: cfg_q.stop_radius <= cfg_wdata[30:0];
					REG_MAX_SPEED: cfg_q.max_speed <= cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (acc && !q_pop)
				credit_q <= credit_q + 1'b1;
			else if (q_pop && !acc)
				credit_q <= credit_q - 1'b1;
		end
	end

	gtp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(acc),
		.pos_x(s_tdata[31:0]),
		.pos_y(s_tdata[63:32]),
		.quat_x(s_tdata[79:64]),
		.quat_y(s_tdata[95:80]),
		.quat_z(s_tdata[111:96]),
		.quat_w(s_tdata[127:112]),
		.cfg(cfg_q),
		.out_valid(fr_valid),
		.out_item(fr_item)
	);

	gtp_fifo #(
		.WIDTH($bits(qitem_t)),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fr_valid),
		.din(fr_item),
		.pop(q_pop),
		.dout(q_item),
		.empty(q_empty)
	);

	gtp_back #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!q_empty),
		.in_item(q_item),
		.in_pop(q_pop),
		.cfg(cfg_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.linear_speed(speed),
		.angular_rate(rate),
		.arrived(arr)
	);

	assign m_tdata = {1'b0, rate, speed};
	assign m_tuser = arr;

`include "go_to_point_steering_assert.svh"

	`GTP_CHECK(a_credit_bound, credit_q <= CRW'(QDEPTH))
	`GTP_IMPLY(a_arrived_zero, m_tvalid && m_tuser, m_tdata == '0)
	`GTP_IMPLY(a_speed_cap, m_tvalid && !m_tuser, m_tdata[30:0] <= cfg_q.max_speed)

endmodule

[tb/sv/go_to_point_steering_checker.sv]
`timescale 1ns / 1ps

module go_to_point_steering_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [127:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [47:0] m_tdata,
	input  logic m_tuser,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_wdata,
	output int errors,
	output int pending
);
	import gtp_pkg::*;

	localparam longint HALF_TURN = 64'sd3373259426;
	localparam longint FULL_TURN = 64'sd6746518852;
	localparam longint ATAN_STEP [0:15] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768
	};

	typedef struct packed {
		logic [30:0] speed;
		logic signed [15:0] rate;
		logic arrived;
	} command_t;

	longint goal_x, goal_y;
	longint unsigned stop_dist, speed_cap;
	command_t command_q[$];

	function automatic longint step_angle(input int i);
		if (i < 16)
			return ATAN_STEP[i];
		else if (i < 31)
			return longint'(1) << (30 - i);
		return 0;
	endfunction

	function automatic longint heading(input longint y_in, input longint x_in);
		longint x, y, z, xs, ys;
		x = x_in;
		y = y_in;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += step_angle(i);
			end else begin
				x -= ys;
				y += xs;
				z -= step_angle(i);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v_in);
		longint unsigned v, res, b;
		v = v_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic command_t steer(input logic [127:0] d);
		command_t c;
		longint px, py, qx, qy, qz, qw, dx, dy, err, lim;
		longint unsigned distance;
		px = longint'($signed(d[31:0]));
		py = longint'($signed(d[63:32]));
		qx = longint'($signed(d[79:64]));
		qy = longint'($signed(d[95:80]));
		qz = longint'($signed(d[111:96]));
		qw = longint'($signed(d[127:112]));
		dx = goal_x - px;
		dy = goal_y - py;
		lim = longint'(1) << 31;
		if (dx >= lim || dx <= -lim || dy >= lim || dy <= -lim)
			distance = 64'd1 << 31;
		else
			distance = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
		c = '0;
		if (distance < stop_dist) begin
			c.arrived = 1'b1;
			return c;
		end
		err = heading(dy, dx) - heading(2 * (qw * qz + qx * qy),
			qw * qw + qx * qx - qy * qy - qz * qz);
		while (err > HALF_TURN)
			err -= FULL_TURN;
		while (err <= -HALF_TURN)
			err += FULL_TURN;
		c.rate = 16'((err + 65536) >>> 17);
		c.speed = 31'((distance > speed_cap) ? speed_cap : distance);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		command_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			goal_x <= 262144;
			goal_y <= 98304;
			stop_dist <= 6554;
			speed_cap <= 58982;
			errors <= 0;
			pending <= 0;
			command_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				command_q.push_back(steer(s_tdata));
			if (m_tvalid && m_tready) begin
				if (command_q.size() == 0) begin
					$error("result with no request outstanding");
					bad++;
				end else begin
					want = command_q.pop_front();
					if (m_tdata[30:0] !== want.speed) begin
						$error("linear_speed expected %0d got %0d", want.speed, m_tdata[30:0]);
						bad++;
					end
					if (m_tdata[46:31] !== want.rate) begin
						$error("angular_rate expected %0d got %0d", want.rate,
							$signed(m_tdata[46:31]));
						bad++;
					end
					if (m_tuser !== want.arrived) begin
						$error("arrived expected %0d got %0d", want.arrived, m_tuser);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			pending <= command_q.size();
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET_X: goal_x <= longint'($signed(cfg_wdata));
					REG_TARGET_Y: goal_y <= longint'($signed(cfg_wdata));
					REG_STOP_RADIUS: stop_dist <= cfg_wdata[30:0];
					REG_MAX_SPEED: speed_cap <= cfg_wdata[30:0];
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/sv/go_to_point_steering_test.sv]
`timescale 1ns / 1ps

module go_to_point_steering_test;
	import gtp_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	int errors, pending;
	int src_idle = 36, snk_idle = 76;
	int cycles = 0;
	int stall_left = 0;
	bit stall_req = 0, stall_done = 0;
	logic signed [31:0] goal_x = 262144, goal_y = 98304;

	always #2 clk = ~clk;

	go_to_point_steering dut (.*);

	go_to_point_steering_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("go_to_point_steering_test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_req && !stall_done) begin
			stall_done <= 1'b1;
			stall_left <= 400;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
			input logic [15:0] qx, input logic [15:0] qy,
			input logic [15:0] qz, input logic [15:0] qw);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {qw, qz, qy, qx, py, px};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || m_tvalid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_goal(input logic [31:0] tx, input logic [31:0] ty,
			input logic [30:0] radius, input logic [30:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= REG_TARGET_X;
		cfg_wdata <= tx;
		@(posedge clk);
		cfg_index <= REG_TARGET_Y;
		cfg_wdata <= ty;
		@(posedge clk);
		cfg_index <= REG_STOP_RADIUS;
		cfg_wdata <= {1'b0, radius};
		@(posedge clk);
		cfg_index <= REG_MAX_SPEED;
		cfg_wdata <= {1'b0, cap};
		@(posedge clk);
		cfg_we <= 1'b0;
		goal_x = tx;
		goal_y = ty;
	endtask

	function automatic logic [15:0] quat_part();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	task automatic random_poses(input int count);
		logic [31:0] px, py;
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(11);
			if (kind < 4) begin
				px = goal_x + 32'($signed($urandom_range(16000)) - 8000);
				py = goal_y + 32'($signed($urandom_range(16000)) - 8000);
			end else if (kind < 8) begin
				px = goal_x + 32'($signed($urandom_range(2000000)) - 1000000);
				py = goal_y + 32'($signed($urandom_range(2000000)) - 1000000);
			end else if (kind < 10) begin
				px = $urandom();
				py = $urandom();
			end else begin
				px = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
				py = $urandom();
			end
			if ($urandom_range(19) == 0)
				send_pose(px, py, 16'd0, 16'd0, 16'd0, 16'd0);
			else
				send_pose(px, py, quat_part(), quat_part(), quat_part(), quat_part());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pose(32'd262144, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd0, 32'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
		send_pose(32'd0, 32'd0, 16'd0, 16'd0, 16'hc000, 16'd16384);
		send_pose(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_pose(32'h80000000, 32'h80000000, 16'hc000, 16'hc000, 16'hc000, 16'hc000);
		send_pose(32'h7fffffff, 32'h7fffffff, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
		send_pose(32'h7fffffff, 32'd98304, 16'd0, 16'd0, 16'd0, 16'hc000);
		send_pose(32'd262144, 32'h80000000, 16'd16384, 16'd0, 16'd0, 16'd0);
		send_pose(32'd300000, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd200000, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd262144, 32'd50000, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd400000, 32'd98305, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd400000, 32'd98303, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd262144 - 32'd6554, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd262144 - 32'd6553, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd262144 - 32'd58982, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd262144 - 32'd58983, 32'd98304, 16'd0, 16'd0, 16'd0, 16'd16384);
		send_pose(32'd0, 32'd98304, 16'd5000, 16'hf000, 16'd12000, 16'h8000);
		random_poses(380);
		drain();

		src_idle = 76;
		snk_idle = 36;
		set_goal(32'h7fffffff, 32'h80000000, 31'd0, 31'h7fffffff);
		send_pose(32'h7fffffff, 32'h80000000, 16'd0, 16'd0, 16'd0, 16'd0);
		send_pose(32'h80000000, 32'h7fffffff, 16'd0, 16'd0, 16'd0, 16'd16384);
		random_poses(380);
		drain();

		src_idle = 0;
		snk_idle = 0;
		set_goal($urandom(), $urandom(), 31'd65536, 31'($urandom_range(2000000)));
		stall_req <= 1'b1;
		random_poses(380);
		drain();

		set_goal(32'hffff0000, 32'd0, 31'h7fffffff, 31'd0);
		random_poses(380);
		drain();

		if (errors == 0)
			$display("go_to_point_steering_test passed");
		else
			$display("go_to_point_steering_test failed");
		$finish;
	end
endmodule
